FILE: rtl/core/sdm_pkg.sv
// Package for the sorted delta merge core: command and register codes,
// the update store word type, the state type and the key and row helpers.
// No dependencies.
`default_nettype none

package sdm_pkg;

    localparam int ID_W            = 64;
    localparam int NUM_IDS         = 4;
    localparam int NUM_COLS        = 6;
    localparam int MAX_UPDATES_DEF = 63;

    // Largest column count that a row may have.
    localparam logic [2:0] MAX_COLUMNS = 3'd6;

    typedef logic [ID_W-1:0]                id_t;
    typedef logic [NUM_IDS-1:0][ID_W-1:0]   ids_t;
    typedef logic [NUM_COLS-1:0][ID_W-1:0]  row_t;

    // Commands.
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD   = 2'd0;
    localparam cmd_t CMD_ROW    = 2'd1;
    localparam cmd_t CMD_FINISH = 2'd2;
    localparam cmd_t CMD_NOP    = 2'd3;

    // Configuration register indexes.
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_KEY_COLUMNS   = 2'd0;
    localparam cfg_idx_t CFG_INCLUDE_GRAPH = 2'd1;
    localparam cfg_idx_t CFG_NUM_COLUMNS   = 2'd2;
    localparam cfg_idx_t CFG_UNDEF_WORD    = 2'd3;

    // One word of the update store.
    typedef struct packed {
        ids_t id;
        logic is_ins;
    } upd_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_ROW  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } cmp_t;

    // Lexicographic unsigned compare of an update key against the row's
    // leading columns. The key starts at id (3 - kc).
    function automatic cmp_t compare_key(input ids_t w, input row_t row,
                                         input logic [1:0] kc, input logic [2:0] len);
        cmp_t       res;
        logic       done;
        logic [1:0] widx;
        res  = CMP_EQ;
        done = 1'b0;
        for (int i = 0; i < NUM_IDS; i++) begin
            widx = 2'(3'd3 - {1'b0, kc} + 3'(i));
            if (!done && (3'(i) < len) && (w[widx] != row[i])) begin
                res  = (w[widx] < row[i]) ? CMP_LT : CMP_GT;
                done = 1'b1;
            end
        end
        return res;
    endfunction

    // Row built from an inserted update: key ids, then the undefined word; unused columns cleared.
    function automatic row_t make_update_row(input ids_t w, input id_t undef,
                                             input logic [1:0] kc, input logic [2:0] len,
                                             input logic [2:0] ncols);
        row_t       res;
        logic [1:0] widx;
        for (int j = 0; j < NUM_COLS; j++) begin
            widx = 2'(3'd3 - {1'b0, kc} + 3'(j));
            if (3'(j) >= ncols) begin
                res[j] = '0;
            end
            else if (3'(j) < len) begin
                res[j] = w[widx];
            end
            else begin
                res[j] = undef;
            end
        end
        return res;
    endfunction

    // Block row with unused columns cleared.
    function automatic row_t mask_row(input row_t row, input logic [2:0] ncols);
        row_t res;
        for (int j = 0; j < NUM_COLS; j++) begin
            res[j] = (3'(j) < ncols) ? row[j] : '0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sorted_delta_merge_core.sv
// Sorted delta merge core: merges sorted block rows with a sorted list of
// pending inserts and deletes held in a synchronous store with a registered read.
// Load: no result. Row: busy while entries are examined and the row word is sent
// (none when a delete drops it); the next word is taken while busy is low.
// Finish: walks the remaining entries, then sends the last word. Each result is
// on the ports the cycle after it is formed; the receiver cannot stall.
// Reset clears pointers and flags asynchronously; the store is not cleared.
`default_nettype none

module sorted_delta_merge_core #(
    parameter int MAX_UPDATES = sdm_pkg::MAX_UPDATES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Command channel.
    input  wire logic               start,
    output logic                    busy,
    input  wire sdm_pkg::cmd_t      cmd,
    input  wire sdm_pkg::id_t       col0,
    input  wire sdm_pkg::id_t       col1,
    input  wire sdm_pkg::id_t       col2,
    input  wire sdm_pkg::id_t       col3,
    input  wire sdm_pkg::id_t       col4,
    input  wire sdm_pkg::id_t       col5,
    input  wire logic               is_insert,
    // Configuration write port.
    input  wire logic               cfg_we,
    input  wire sdm_pkg::cfg_idx_t  cfg_index,
    input  wire sdm_pkg::id_t       cfg_data,
    // Result channel.
    output logic                    result_strobe,
    output sdm_pkg::id_t            out0,
    output sdm_pkg::id_t            out1,
    output sdm_pkg::id_t            out2,
    output sdm_pkg::id_t            out3,
    output sdm_pkg::id_t            out4,
    output sdm_pkg::id_t            out5,
    output logic                    from_update,
    output logic                    no_row,
    output logic                    last,
    output logic                    overflow
);
    import sdm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_UPDATES + 1);
    localparam int ADDR_W = (MAX_UPDATES > 1) ? $clog2(MAX_UPDATES) : 1;

    // Configuration registers.
    logic [1:0] key_columns_reg;
    logic       include_graph_reg;
    logic [2:0] num_columns_reg;
    id_t        undef_word_reg;

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             ovf_reg, ovf_next;
    logic             op_fin_reg, op_fin_next;
    logic             pend_vld_reg, pend_vld_next;
    row_t             row_reg, row_next;
    row_t             pend_reg, pend_next;

    // Result registers.
    logic strobe_reg, strobe_next;
    row_t out_reg, out_next;
    logic from_upd_reg, from_upd_next;
    logic no_row_reg, no_row_next;
    logic last_reg, last_next;
    logic ovf_out_reg, ovf_out_next;

    // Update store.
    upd_entry_t             mem [MAX_UPDATES];
    upd_entry_t             mem_q;
    upd_entry_t             wr_entry;
    logic                   mem_we;
    logic [ADDR_W-1:0]      rd_addr;

    // Derived settings and datapath values.
    logic [1:0]       kc_eff;
    logic [2:0]       ncols;
    logic [2:0]       klen;
    cmp_t             cmp_res;
    row_t             upd_row;
    row_t             in_row;
    logic [CNT_W-1:0] ptr_inc;
    logic             more;
    logic             accept;

    assign in_row = {col5, col4, col3, col2, col1, col0};
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Effective key length and column count.
    always_comb
    begin
        kc_eff = (key_columns_reg == 2'd0) ? 2'd1 : key_columns_reg;
        if (num_columns_reg == 3'd0) begin
            ncols = 3'd1;
        end
        else if (num_columns_reg > MAX_COLUMNS) begin
            ncols = MAX_COLUMNS;
        end
        else begin
            ncols = num_columns_reg;
        end
        klen = {1'b0, kc_eff} + {2'b0, include_graph_reg};
    end

    assign cmp_res = compare_key(mem_q.id, row_reg, kc_eff, klen);
    assign upd_row = make_update_row(mem_q.id, undef_word_reg, kc_eff, klen, ncols);
    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign more    = (ptr_inc < cnt_reg);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_columns_reg   <= 2'd3;
            include_graph_reg <= 1'b1;
            num_columns_reg   <= 3'd4;
            undef_word_reg    <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_COLUMNS:   key_columns_reg   <= cfg_data[1:0];
                CFG_INCLUDE_GRAPH: include_graph_reg <= cfg_data[0];
                CFG_NUM_COLUMNS:   num_columns_reg   <= cfg_data[2:0];
                CFG_UNDEF_WORD:    undef_word_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Sequencer: walks the update store one entry a cycle while in the compare state.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        ovf_next      = ovf_reg;
        op_fin_next   = op_fin_reg;
        pend_vld_next = pend_vld_reg;
        row_next      = row_reg;
        pend_next     = pend_reg;
        strobe_next   = 1'b0;
        out_next      = out_reg;
        from_upd_next = from_upd_reg;
        no_row_next   = no_row_reg;
        last_next     = last_reg;
        ovf_out_next  = ovf_out_reg;
        mem_we        = 1'b0;
        wr_entry.id   = {col3, col2, col1, col0};
        wr_entry.is_ins = is_insert;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            if (cnt_reg < CNT_W'(MAX_UPDATES)) begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            else begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_ROW:
                        begin
                            row_next    = in_row;
                            op_fin_next = 1'b0;
                            state_next  = (ptr_reg < cnt_reg) ? ST_CMP : ST_ROW;
                        end
                        CMD_FINISH:
                        begin
                            op_fin_next   = 1'b1;
                            pend_vld_next = 1'b0;
                            state_next    = (ptr_reg < cnt_reg) ? ST_CMP : ST_FIN;
                        end
                        default: ;
                    endcase
                end
            end

            ST_CMP:
            begin
                if (op_fin_reg) begin
                    // Finish: hold one insert back so the last one can be marked.
                    ptr_next = ptr_inc;
                    if (mem_q.is_ins) begin
                        if (pend_vld_reg) begin
                            strobe_next   = 1'b1;
                            out_next      = pend_reg;
                            from_upd_next = 1'b1;
                            no_row_next   = 1'b0;
                            last_next     = 1'b0;
                            ovf_out_next  = ovf_reg;
                        end
                        pend_next     = upd_row;
                        pend_vld_next = 1'b1;
                    end
                    state_next = more ? ST_CMP : ST_FIN;
                end
                else if (cmp_res == CMP_GT) begin
                    state_next = ST_ROW;
                end
                else begin
                    ptr_next = ptr_inc;
                    if (cmp_res == CMP_LT && mem_q.is_ins) begin
                        strobe_next   = 1'b1;
                        out_next      = upd_row;
                        from_upd_next = 1'b1;
                        no_row_next   = 1'b0;
                        last_next     = 1'b0;
                        ovf_out_next  = ovf_reg;
                    end
                    if (cmp_res == CMP_EQ && !mem_q.is_ins) begin
                        // Matching delete drops the row.
                        state_next = ST_IDLE;
                    end
                    else begin
                        state_next = more ? ST_CMP : ST_ROW;
                    end
                end
            end

            ST_ROW:
            begin
                strobe_next   = 1'b1;
                out_next      = mask_row(row_reg, ncols);
                from_upd_next = 1'b0;
                no_row_next   = 1'b0;
                last_next     = 1'b0;
                ovf_out_next  = ovf_reg;
                state_next    = ST_IDLE;
            end

            ST_FIN:
            begin
                strobe_next   = 1'b1;
                out_next      = pend_vld_reg ? pend_reg : '0;
                from_upd_next = pend_vld_reg;
                no_row_next   = !pend_vld_reg;
                last_next     = 1'b1;
                ovf_out_next  = ovf_reg;
                pend_vld_next = 1'b0;
                cnt_next      = '0;
                ptr_next      = '0;
                ovf_next      = 1'b0;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The store is read at the entry the sequencer will look at next.
    assign rd_addr = ptr_next[ADDR_W-1:0];

    // Update store: at most one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[cnt_reg[ADDR_W-1:0]] <= wr_entry;
        end
        mem_q <= mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            ovf_reg      <= 1'b0;
            op_fin_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            ovf_reg      <= ovf_next;
            op_fin_reg   <= op_fin_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        from_upd_reg <= from_upd_next;
        no_row_reg   <= no_row_next;
        last_reg     <= last_next;
        ovf_out_reg  <= ovf_out_next;
    end

    // Result ports.
    assign result_strobe = strobe_reg;
    assign out0          = out_reg[0];
    assign out1          = out_reg[1];
    assign out2          = out_reg[2];
    assign out3          = out_reg[3];
    assign out4          = out_reg[4];
    assign out5          = out_reg[5];
    assign from_update   = from_upd_reg;
    assign no_row        = no_row_reg;
    assign last          = last_reg;
    assign overflow      = ovf_out_reg;

    // The read pointer never passes the fill count.
    assert property (@(posedge clk) disable iff (!rst_n) ptr_reg <= cnt_reg)
        else $error("read pointer beyond fill count");

    // An entry is compared only when it has been loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> ptr_reg < cnt_reg)
        else $error("compare on an unloaded entry");

    // An end marker is always the last word of a finish.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && no_row |-> last && !from_update)
        else $error("end marker without last");

    // A finish leaves the store empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> cnt_reg == '0 && ptr_reg == '0 && result_strobe && last)
        else $error("finish did not reset the store");

endmodule

`default_nettype wire
